// File: src/iirtdf2_pkg.sv
// Shared constants, types and saturation helper for the transposed DF-II IIR filter.
// No dependencies; every other file in src imports this package.
package iirtdf2_pkg;

	localparam int MAX_ORDER      = 3;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 20;
	localparam int COEF_FRAC_BITS = 16;
	localparam int STATE_BITS     = 40;
	localparam int ORDER_BITS     = 2;
	localparam int DATA_BITS      = 32;
	localparam int REG_IDX_BITS   = 3;
	localparam int ADDR_BITS      = REG_IDX_BITS + 2;

	// product and accumulator widths
	localparam int BU_BITS  = SAMPLE_BITS + COEF_BITS;
	localparam int AY_BITS  = STATE_BITS + COEF_BITS;
	localparam int ACC_BITS = AY_BITS - COEF_FRAC_BITS + 2;

	localparam logic [REG_IDX_BITS-1:0] REG_ORDER = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_B0    = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_B1    = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_B2    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_B3    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_A1    = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_A2    = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_A3    = 3'd7;

	localparam logic KIND_FILTER = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef struct packed {
		logic [ORDER_BITS-1:0]               order;
		logic [MAX_ORDER:0][COEF_BITS-1:0]   b;
		logic [MAX_ORDER:1][COEF_BITS-1:0]   a;
	} cfg_t;

	typedef struct packed {
		logic load_bu;
		logic load_ay;
		logic update;
		logic clear;
		logic active;
		logic last;
	} cell_ctrl_t;

	typedef struct packed {
		logic [STATE_BITS-1:0] val;
		logic                  clip;
	} sat_t;

	function automatic sat_t sat_state(input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] hi;
		logic signed [ACC_BITS-1:0] lo;
		sat_t r;
		hi = (ACC_BITS'(1) <<< (STATE_BITS - 1)) - ACC_BITS'(1);
		lo = -hi - ACC_BITS'(1);
		r.clip = 1'b0;
		r.val  = v[STATE_BITS-1:0];
		if (v > hi) begin
			r.val  = hi[STATE_BITS-1:0];
			r.clip = 1'b1;
		end else if (v < lo) begin
			r.val  = lo[STATE_BITS-1:0];
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: src/iirtdf2_in_if.sv
// Sample channel: valid/ready handshake carrying one filter or clear item.
// Depends on iirtdf2_pkg.
interface iirtdf2_in_if import iirtdf2_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, kind, sample_in, input ready);
	modport sink (input valid, kind, sample_in, output ready);
endinterface

// File: src/iirtdf2_out_if.sv
// Result channel: valid/ready handshake carrying one filtered sample and clip flag.
// Depends on iirtdf2_pkg.
interface iirtdf2_out_if import iirtdf2_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered_out;
	logic                          clipped;

	modport source (output valid, filtered_out, clipped, input ready);
	modport sink (input valid, filtered_out, clipped, output ready);
endinterface

// File: src/iirtdf2_regs.sv
// APB configuration registers: filter order and the b/a coefficient set.
// Depends on iirtdf2_pkg.
module iirtdf2_regs import iirtdf2_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output cfg_t                 cfg
);

	// order 1, b0 = 1.0 in the low slot of b, everything else zero
	localparam cfg_t CFG_RESET = '{
		order: ORDER_BITS'(1),
		b:     (COEF_BITS * (MAX_ORDER + 1))'(1) << COEF_FRAC_BITS,
		a:     '0
	};

	cfg_t                    cfg_q;
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr;

	assign idx = paddr[ADDR_BITS-1:2];
	// pready is tied high, so the access phase always completes
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			case (idx)
				REG_ORDER: cfg_q.order <= pwdata[ORDER_BITS-1:0];
				REG_B0:    cfg_q.b[0]  <= pwdata[COEF_BITS-1:0];
				REG_B1:    cfg_q.b[1]  <= pwdata[COEF_BITS-1:0];
				REG_B2:    cfg_q.b[2]  <= pwdata[COEF_BITS-1:0];
				REG_B3:    cfg_q.b[3]  <= pwdata[COEF_BITS-1:0];
				REG_A1:    cfg_q.a[1]  <= pwdata[COEF_BITS-1:0];
				REG_A2:    cfg_q.a[2]  <= pwdata[COEF_BITS-1:0];
				REG_A3:    cfg_q.a[3]  <= pwdata[COEF_BITS-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORDER: prdata = DATA_BITS'(cfg_q.order);
			REG_B0:    prdata = DATA_BITS'($signed(cfg_q.b[0]));
			REG_B1:    prdata = DATA_BITS'($signed(cfg_q.b[1]));
			REG_B2:    prdata = DATA_BITS'($signed(cfg_q.b[2]));
			REG_B3:    prdata = DATA_BITS'($signed(cfg_q.b[3]));
			REG_A1:    prdata = DATA_BITS'($signed(cfg_q.a[1]));
			REG_A2:    prdata = DATA_BITS'($signed(cfg_q.a[2]));
			REG_A3:    prdata = DATA_BITS'($signed(cfg_q.a[3]));
			default:   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: src/iirtdf2_cell.sv
// One delay cell of the transposed DF-II chain: holds s[i-1], forms b[i]*u and a[i]*y,
// and takes s[i] from its right neighbor. Depends on iirtdf2_pkg.
module iirtdf2_cell import iirtdf2_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctrl_t                    ctrl,
	input  logic signed [COEF_BITS-1:0]   coef_b,
	input  logic signed [COEF_BITS-1:0]   coef_a,
	input  logic signed [SAMPLE_BITS-1:0] u,
	input  logic signed [STATE_BITS-1:0]  y,
	input  logic signed [STATE_BITS-1:0]  next_state,
	output logic signed [STATE_BITS-1:0]  state,
	output logic                          clip
);

	localparam logic signed [AY_BITS-1:0] AY_HALF = AY_BITS'(1) <<< (COEF_FRAC_BITS - 1);

	logic signed [BU_BITS-1:0]    bu_s1;
	logic signed [AY_BITS-1:0]    ay_s3;
	logic signed [STATE_BITS-1:0] state_q;
	logic signed [AY_BITS-1:0]    ay_half;
	logic signed [AY_BITS-1:0]    ay_rnd;
	logic signed [STATE_BITS-1:0] link;
	logic signed [ACC_BITS-1:0]   acc;
	sat_t                         acc_sat;

	always_ff @(posedge clk) begin
		if (ctrl.load_bu) begin
			bu_s1 <= coef_b * u;
		end
		if (ctrl.load_ay) begin
			ay_s3 <= coef_a * y;
		end
	end

	// a*y rounded to Q.16: add one half, floor shift
	always_comb begin
		ay_half = ay_s3 + AY_HALF;
		ay_rnd  = ay_half >>> COEF_FRAC_BITS;
		link    = ctrl.last ? '0 : next_state;
		acc     = ACC_BITS'(bu_s1) - $signed(ay_rnd[ACC_BITS-1:0]) + ACC_BITS'(link);
		acc_sat = sat_state(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctrl.clear) begin
			state_q <= '0;
		end else if (ctrl.update && ctrl.active) begin
			state_q <= acc_sat.val;
		end
	end

	assign state = state_q;
	assign clip  = ctrl.active & acc_sat.clip;

endmodule

// File: src/iir_filter_transposed_df2_unit.sv
// Transposed DF-II IIR filter, order 1..3, row of delay cells with APB coefficient registers.
// A filter sample runs through the steps MUL, SUM, FB and UPD; UPD holds while the previous result still waits.
// A new sample is accepted only in idle, once the four-step sequence through the cell row is done.
// A clear item zeroes the delay states, leaves the unit idle and produces no result.
// Reset (arst_n low) zeroes the delay states, sets order 1, b0 = 1.0, other coefficients 0.
// Depends on iirtdf2_pkg, iirtdf2_in_if, iirtdf2_out_if, iirtdf2_regs, iirtdf2_cell.
module iir_filter_transposed_df2_unit import iirtdf2_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	iirtdf2_in_if.sink           sample_ch,
	iirtdf2_out_if.source        result_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_FB   = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;

	localparam logic signed [STATE_BITS:0] Y_HALF =
		(STATE_BITS + 1)'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [STATE_BITS:0] OUT_HI =
		(STATE_BITS + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [STATE_BITS:0] OUT_LO = -OUT_HI - (STATE_BITS + 1)'(1);

	cfg_t                          cfg;
	logic [2:0]                    step_q;
	logic signed [SAMPLE_BITS-1:0] u_q;
	logic signed [BU_BITS-1:0]     p0_s1;
	logic signed [STATE_BITS-1:0]  y_s2;
	logic                          clip_y_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_clip_q;

	logic                          in_acc;
	logic                          slot_free;
	logic                          upd_fire;
	logic [ORDER_BITS-1:0]         ord_eff;
	logic signed [ACC_BITS-1:0]    ysum;
	sat_t                          ysat;
	logic signed [STATE_BITS:0]    y_half;
	logic signed [STATE_BITS:0]    y_int;
	logic signed [STATE_BITS:0]    y_out;
	logic                          out_sat;

	logic signed [STATE_BITS-1:0]  chain_st [1:MAX_ORDER+1];
	logic [MAX_ORDER:1]            cell_clip;
	cell_ctrl_t                    cell_ctrl [1:MAX_ORDER];

	assign pready = 1'b1;

	iirtdf2_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign sample_ch.ready = (step_q == ST_IDLE);
	assign in_acc          = sample_ch.valid & sample_ch.ready;
	assign slot_free       = !out_valid_q || result_ch.ready;
	assign upd_fire        = (step_q == ST_UPD) && slot_free;

	// order 0 behaves as order 1, anything above the cell count as the cell count
	always_comb begin
		ord_eff = (cfg.order == '0) ? ORDER_BITS'(1) : cfg.order;
		if (ord_eff > ORDER_BITS'(MAX_ORDER)) begin
			ord_eff = ORDER_BITS'(MAX_ORDER);
		end
	end

	assign chain_st[MAX_ORDER+1] = '0;

	for (genvar i = 1; i <= MAX_ORDER; i++) begin : g_cell
		always_comb begin
			cell_ctrl[i].load_bu = (step_q == ST_MUL);
			cell_ctrl[i].load_ay = (step_q == ST_FB);
			cell_ctrl[i].update  = upd_fire;
			cell_ctrl[i].clear   = in_acc && (sample_ch.kind == KIND_CLEAR);
			cell_ctrl[i].active  = (ORDER_BITS'(i) <= ord_eff);
			cell_ctrl[i].last    = (ORDER_BITS'(i) == ord_eff);
		end

		iirtdf2_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl[i]),
			.coef_b     ($signed(cfg.b[i])),
			.coef_a     ($signed(cfg.a[i])),
			.u          (u_q),
			.y          (y_s2),
			.next_state (chain_st[i+1]),
			.state      (chain_st[i]),
			.clip       (cell_clip[i])
		);
	end

	always_comb begin
		ysum = ACC_BITS'(p0_s1) + ACC_BITS'(chain_st[1]);
		ysat = sat_state(ysum);
	end

	// output: y rounded half up to an integer, then clipped to the sample range
	always_comb begin
		y_half  = (STATE_BITS + 1)'(y_s2) + Y_HALF;
		y_int   = y_half >>> COEF_FRAC_BITS;
		out_sat = 1'b0;
		y_out   = y_int;
		if (y_int > OUT_HI) begin
			y_out   = OUT_HI;
			out_sat = 1'b1;
		end else if (y_int < OUT_LO) begin
			y_out   = OUT_LO;
			out_sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (in_acc && sample_ch.kind == KIND_FILTER) begin
						step_q <= ST_MUL;
					end
				end
				ST_MUL:  step_q <= ST_SUM;
				ST_SUM:  step_q <= ST_FB;
				ST_FB:   step_q <= ST_UPD;
				ST_UPD: begin
					if (slot_free) begin
						step_q <= ST_IDLE;
					end
				end
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_q <= sample_ch.sample_in;
		end
		if (step_q == ST_MUL) begin
			p0_s1 <= $signed(cfg.b[0]) * u_q;
		end
		if (step_q == ST_SUM) begin
			y_s2      <= ysat.val;
			clip_y_s2 <= ysat.clip;
		end
		if (upd_fire) begin
			out_data_q <= y_out[SAMPLE_BITS-1:0];
			out_clip_q <= clip_y_s2 | out_sat | (|cell_clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.filtered_out = out_data_q;
	assign result_ch.clipped      = out_clip_q;

`ifndef SYNTHESIS
	a_filter_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && sample_ch.kind == KIND_FILTER) |=> (step_q == ST_MUL))
		else $error("filter transfer did not start the cell sequence");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && sample_ch.kind == KIND_CLEAR) |=> (chain_st[1] == '0 && step_q == ST_IDLE))
		else $error("clear transfer left state or sequence busy");

	a_update_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid_q)
		else $error("state update without a result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(step_q) == ST_UPD))
		else $error("result appeared outside the update step");
`endif

endmodule

// File: dv/iir_filter_transposed_df2_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for iir_filter_transposed_df2_unit: directed script, then random phases.
// Depends on iirtdf2_pkg, iirtdf2_in_if, iirtdf2_out_if and the unit itself.
module iir_filter_transposed_df2_unit_tb import iirtdf2_pkg::*; ();

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered_out;
		logic                          clipped;
	} result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

	typedef struct packed {
		row_op_e                       op;
		logic                          kind;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [REG_IDX_BITS-1:0]       idx;
		logic [DATA_BITS-1:0]          val;
		logic                          known;
		logic signed [SAMPLE_BITS-1:0] want_out;
		logic                          want_clip;
	} row_t;

	localparam int SCRIPT_LEN  = 32;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 107;
	localparam int SETTLE      = 10;

	// known rows: reset defaults and saturated extremes; the rest go through the predictor
	localparam row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{ROW_ITEM, KIND_FILTER, 16'h0000, REG_ORDER, 32'h0, 1'b1, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h7FFF, REG_ORDER, 32'h0, 1'b1, 16'h7FFF, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h8000, REG_ORDER, 32'h0, 1'b1, 16'h8000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'hFFFF, REG_ORDER, 32'h0, 1'b1, 16'hFFFF, 1'b0},
		'{ROW_ITEM, KIND_CLEAR,  16'h0000, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B0, 32'h0007FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h7FFF, REG_ORDER, 32'h0, 1'b1, 16'h7FFF, 1'b1},
		'{ROW_ITEM, KIND_FILTER, 16'h8000, REG_ORDER, 32'h0, 1'b1, 16'h8000, 1'b1},
		'{ROW_ITEM, KIND_FILTER, 16'h0000, REG_ORDER, 32'h0, 1'b1, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B0, 32'hFFF80000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h7FFF, REG_ORDER, 32'h0, 1'b1, 16'h8000, 1'b1},
		'{ROW_ITEM, KIND_FILTER, 16'h8000, REG_ORDER, 32'h0, 1'b1, 16'h7FFF, 1'b1},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B0, 32'h00010000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_ORDER, 32'h00000003, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B1, 32'h0007FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B2, 32'h0007FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_B3, 32'h0007FFFF, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_A1, 32'hFFF80000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_A2, 32'hFFF80000, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_A3, 32'hFFF80000, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h7FFF, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h8000, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h03E8, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'hFFFF, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		// order 1 leaves the upper states alone, order 0 acts as 1, order 3 picks them up again
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_ORDER, 32'hFFFFFFFD, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h0007, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_ORDER, 32'h5A5A0004, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h012C, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  KIND_FILTER, 16'h0000, REG_ORDER, 32'h00000003, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'hFFFB, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_CLEAR,  16'h0000, REG_ORDER, 32'h0, 1'b0, 16'h0000, 1'b0},
		'{ROW_ITEM, KIND_FILTER, 16'h0000, REG_ORDER, 32'h0, 1'b1, 16'h0000, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	iirtdf2_in_if  sample_ch ();
	iirtdf2_out_if result_ch ();

	iir_filter_transposed_df2_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int src_idle = 23;
	int snk_idle = 63;
	int mismatch_count = 0;

	// predictor copy of the filter
	logic [ORDER_BITS-1:0] order_q;
	longint coef_b [0:MAX_ORDER];
	longint coef_a [0:MAX_ORDER];
	longint dstate [0:MAX_ORDER-1];
	bit     clip_seen;

	result_t pending_results [$];

	task automatic flag_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic longint clamp(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip_seen = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip_seen = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// round half up, dropping the coefficient fraction
	function automatic longint round_frac(longint v);
		return (v + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	function automatic result_t filter_step(logic signed [SAMPLE_BITS-1:0] u_in);
		longint u, y, acc;
		int n;
		result_t r;
		n = (order_q == '0) ? 1 : int'(order_q);
		if (n > MAX_ORDER)
			n = MAX_ORDER;
		u = u_in;
		clip_seen = 1'b0;
		y = clamp(coef_b[0] * u + dstate[0], STATE_BITS);
		for (int i = 1; i <= n; i++) begin
			acc = coef_b[i] * u - round_frac(coef_a[i] * y);
			if (i < n)
				acc += dstate[i];
			dstate[i-1] = clamp(acc, STATE_BITS);
		end
		r.filtered_out = SAMPLE_BITS'(clamp(round_frac(y), SAMPLE_BITS));
		r.clipped = clip_seen;
		return r;
	endfunction

	function automatic void cfg_apply(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
		longint c;
		c = longint'($signed(val[COEF_BITS-1:0]));
		case (idx)
			REG_ORDER: order_q = val[ORDER_BITS-1:0];
			REG_B0: coef_b[0] = c;
			REG_B1: coef_b[1] = c;
			REG_B2: coef_b[2] = c;
			REG_B3: coef_b[3] = c;
			REG_A1: coef_a[1] = c;
			REG_A2: coef_a[2] = c;
			REG_A3: coef_a[3] = c;
			default: ;
		endcase
	endfunction

	// hold off the sender until the unit has nothing in flight
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cfg_apply(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_item(logic k, logic signed [SAMPLE_BITS-1:0] smp, logic known,
			logic signed [SAMPLE_BITS-1:0] want_out, logic want_clip);
		result_t r;
		while ($urandom_range(0, 99) < src_idle) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.kind      <= k;
		sample_ch.sample_in <= smp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		if (k == KIND_CLEAR) begin
			for (int i = 0; i < MAX_ORDER; i++)
				dstate[i] = 0;
		end else begin
			r = filter_step(smp);
			if (known) begin
				r.filtered_out = want_out;
				r.clipped      = want_clip;
			end
			pending_results.push_back(r);
		end
		@(negedge clk);
	endtask

	function automatic logic [DATA_BITS-1:0] pick_coef(int phase, int span);
		logic [COEF_BITS-1:0] c;
		int sel;
		sel = $urandom_range(0, 99);
		if (phase == 1)
			c = 20'h7FFFF;
		else if (phase == 2)
			c = 20'h80000;
		else if (sel < 70)
			c = COEF_BITS'(int'($urandom_range(0, 2 * span)) - span);
		else if (sel < 85)
			c = COEF_BITS'($urandom);
		else
			c = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
		return {12'($urandom), c};
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		if (sel < 25)
			return SAMPLE_BITS'(int'($urandom_range(0, 127)) - 64);
		return SAMPLE_BITS'($urandom);
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result out=%0d clip=%0b",
					result_ch.filtered_out, result_ch.clipped));
			end else begin
				want = pending_results.pop_front();
				if (result_ch.filtered_out !== want.filtered_out)
					flag_mismatch($sformatf("filtered_out got %0d want %0d",
						result_ch.filtered_out, want.filtered_out));
				if (result_ch.clipped !== want.clipped)
					flag_mismatch($sformatf("clipped got %0b want %0b",
						result_ch.clipped, want.clipped));
			end
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.kind      = KIND_FILTER;
		sample_ch.sample_in = '0;

		order_q = ORDER_BITS'(1);
		for (int i = 0; i <= MAX_ORDER; i++) begin
			coef_b[i] = 0;
			coef_a[i] = 0;
		end
		coef_b[0] = longint'(1) <<< COEF_FRAC_BITS;
		for (int i = 0; i < MAX_ORDER; i++)
			dstate[i] = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].op == ROW_CFG)
				write_reg(SCRIPT[i].idx, SCRIPT[i].val);
			else
				send_item(SCRIPT[i].kind, SCRIPT[i].smp, SCRIPT[i].known,
					SCRIPT[i].want_out, SCRIPT[i].want_clip);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < NUM_PHASES / 3) begin
				src_idle = 23;
				snk_idle = 63;
			end else if (p < 2 * NUM_PHASES / 3) begin
				src_idle = 63;
				snk_idle = 23;
			end else begin
				src_idle = 0;
				snk_idle = 0;
			end
			write_reg(REG_ORDER, {30'($urandom), ORDER_BITS'(p % 4)});
			write_reg(REG_B0, pick_coef(p, 65536));
			for (int r = REG_B1; r <= REG_A3; r++)
				write_reg(REG_IDX_BITS'(r), pick_coef(p, 16384));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 99) < 3)
					send_item(KIND_CLEAR, SAMPLE_BITS'($urandom), 1'b0, '0, 1'b0);
				else
					send_item(KIND_FILTER, pick_sample(), 1'b0, '0, 1'b0);
			end
		end

		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
